// File: rtl/core/tsj_pkg.sv
`timescale 1ns / 1ps

package tsj_pkg;

  localparam int MAX_THREADS = 1024;
  localparam int IDW = $clog2(MAX_THREADS + 1);
  localparam int AW = $clog2(MAX_THREADS);

  typedef logic [IDW-1:0] tid_t;
  typedef logic [AW-1:0] taddr_t;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_EXIT = 3'd1;
  localparam logic [2:0] OP_JOIN = 3'd2;
  localparam logic [2:0] OP_PAUSE = 3'd3;
  localparam logic [2:0] OP_TICK = 3'd4;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_HALTED = 2'd2;

  typedef enum logic [2:0] {
    PH_UNUSED,
    PH_RUNNABLE,
    PH_RUNNING,
    PH_BLOCKED,
    PH_EXITED
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic queued;
    logic [31:0] exit_val;
    tid_t wfirst;
    tid_t wlast;
    tid_t wnext;
    logic rpend;
    logic [31:0] rval;
  } thread_rec_t;

  typedef struct packed {
    logic we;
    taddr_t addr;
    thread_rec_t data;
  } tab_wr_t;

  typedef struct packed {
    logic push;
    tid_t push_id;
    logic pop;
  } ring_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] ret;
    tid_t running;
    logic switched;
    logic rvld;
    logic [31:0] rcode;
  } result_t;

endpackage

// File: rtl/core/tsj_thread_tab.sv
`timescale 1ns / 1ps

module tsj_thread_tab (
  input  logic                clk,
  input  tsj_pkg::tab_wr_t    wr,
  input  tsj_pkg::taddr_t     raddr,
  output tsj_pkg::thread_rec_t rdata
);
  import tsj_pkg::*;

  thread_rec_t mem [MAX_THREADS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/tsj_ready_ring.sv
`timescale 1ns / 1ps

module tsj_ready_ring (
  input  logic               clk,
  input  logic               rst,
  input  tsj_pkg::ring_req_t req,
  output tsj_pkg::tid_t      pop_id,
  output tsj_pkg::tid_t      fill
);
  import tsj_pkg::*;

  tid_t ring [MAX_THREADS];
  taddr_t head;
  taddr_t tail;

  always_ff @(posedge clk) begin
    if (req.push) begin
      ring[tail] <= req.push_id;
    end
    pop_id <= ring[head];
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (req.push) begin
        tail <= (tail == taddr_t'(MAX_THREADS - 1)) ? '0 : tail + taddr_t'(1);
      end
      if (req.pop) begin
        head <= (head == taddr_t'(MAX_THREADS - 1)) ? '0 : head + taddr_t'(1);
      end
      unique case ({req.push, req.pop})
        2'b10: fill <= fill + tid_t'(1);
        2'b01: fill <= fill - tid_t'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/core/tsj_ctrl.sv
`timescale 1ns / 1ps

module tsj_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_take,
  input  logic [2:0]           op_in,
  input  tsj_pkg::tid_t        tgt_in,
  input  logic [31:0]          code_in,
  output logic                 ready,
  output logic                 fin,
  input  logic                 res_take,
  output tsj_pkg::result_t     res,
  output tsj_pkg::tab_wr_t     tab_wr,
  output tsj_pkg::taddr_t      tab_raddr,
  input  tsj_pkg::thread_rec_t tab_rdata,
  output tsj_pkg::ring_req_t   ring_req,
  input  tsj_pkg::tid_t        ring_pop_id,
  input  tsj_pkg::tid_t        ring_fill
);
  import tsj_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECODE, S_EX_RD, S_EX_WALK, S_EX_WK, S_EX_JA, S_EX_JAW,
    S_POP0, S_POP1, S_POP2, S_RV_WR, S_JB_RD, S_JT_RD, S_JC_RD, S_LK_IS,
    S_LK_RD, S_LK_LW, S_PS_RD, S_FIN
  } state_t;

  state_t state;
  tid_t created;
  tid_t cur;
  tid_t ja;
  tid_t alive;
  logic halted;
  logic [2:0] op;
  tid_t tgt;
  logic [31:0] code;
  tid_t self;
  tid_t w;
  tid_t guard;
  tid_t nid;
  tid_t lid;
  logic [1:0] st;
  logic [31:0] rv;
  logic sw;
  logic rvld;
  logic [31:0] rcode;

  tid_t new_id;
  logic ring_room;
  logic wake_push;
  thread_rec_t wake_rec;
  thread_rec_t rec;

  function automatic taddr_t to_addr(input tid_t id);
    tid_t t;
    t = id - tid_t'(1);
    return t[AW-1:0];
  endfunction

  function automatic logic id_ok(input tid_t id, input tid_t top);
    return (id != '0) && (id <= top);
  endfunction

  assign rec = tab_rdata;
  assign new_id = created + tid_t'(1);
  assign ring_room = ring_fill < tid_t'(MAX_THREADS);
  assign wake_push = !rec.queued && ring_room;
  assign ready = (state == S_IDLE);
  assign fin = (state == S_FIN);

  assign res.status = st;
  assign res.ret = rv;
  assign res.running = cur;
  assign res.switched = sw;
  assign res.rvld = rvld;
  assign res.rcode = rcode;

  always_comb begin
    wake_rec = rec;
    wake_rec.phase = PH_RUNNABLE;
    wake_rec.rpend = 1'b1;
    wake_rec.rval = (state == S_EX_WK) ? code : '0;
    wake_rec.queued = rec.queued | wake_push;
  end

  always_comb begin
    tab_wr = '0;
    tab_raddr = to_addr(self);
    ring_req = '0;
    unique case (state)
      S_INIT: begin
        tab_wr.we = 1'b1;
        tab_wr.addr = '0;
        tab_wr.data.phase = PH_RUNNING;
      end
      S_DECODE: begin
        if (!halted && op == OP_CREATE && created < tid_t'(MAX_THREADS)) begin
          tab_wr.we = 1'b1;
          tab_wr.addr = to_addr(new_id);
          tab_wr.data.phase = PH_RUNNABLE;
          tab_wr.data.queued = ring_room;
          ring_req.push = ring_room;
          ring_req.push_id = new_id;
        end
        if (op == OP_JOIN && tgt != '0) begin
          tab_raddr = to_addr(tgt);
        end
      end
      S_EX_RD: begin
        tab_wr.we = 1'b1;
        tab_wr.addr = to_addr(self);
        tab_wr.data = rec;
        tab_wr.data.exit_val = code;
        tab_wr.data.phase = PH_EXITED;
        tab_wr.data.wfirst = '0;
      end
      S_EX_WALK: tab_raddr = to_addr(w);
      S_EX_WK: begin
        if (rec.phase == PH_BLOCKED) begin
          tab_wr.we = 1'b1;
          tab_wr.addr = to_addr(w);
          tab_wr.data = wake_rec;
          ring_req.push = wake_push;
          ring_req.push_id = w;
        end
      end
      S_EX_JA: tab_raddr = to_addr(ja);
      S_EX_JAW: begin
        if (rec.phase == PH_BLOCKED) begin
          tab_wr.we = 1'b1;
          tab_wr.addr = to_addr(ja);
          tab_wr.data = wake_rec;
          ring_req.push = wake_push;
          ring_req.push_id = ja;
        end
      end
      S_POP0: ring_req.pop = (ring_fill != '0);
      S_POP1: tab_raddr = to_addr(ring_pop_id);
      S_POP2: begin
        tab_wr.we = 1'b1;
        tab_wr.addr = to_addr(nid);
        tab_wr.data = rec;
        tab_wr.data.queued = 1'b0;
        if (rec.phase == PH_RUNNABLE) begin
          tab_wr.data.phase = PH_RUNNING;
          tab_wr.data.rpend = 1'b0;
        end
      end
      S_RV_WR: begin
        tab_wr.we = 1'b1;
        tab_wr.addr = to_addr(self);
        tab_wr.data = rec;
        tab_wr.data.phase = PH_RUNNING;
      end
      S_JB_RD: begin
        tab_wr.we = 1'b1;
        tab_wr.addr = to_addr(self);
        tab_wr.data = rec;
        tab_wr.data.phase = PH_BLOCKED;
      end
      S_JT_RD: tab_raddr = to_addr(self);
      S_JC_RD: begin
        tab_wr.we = 1'b1;
        tab_wr.addr = to_addr(self);
        tab_wr.data = rec;
        tab_wr.data.phase = PH_BLOCKED;
        tab_wr.data.wnext = '0;
      end
      S_LK_IS: tab_raddr = to_addr(tgt);
      S_LK_RD: begin
        tab_wr.we = 1'b1;
        tab_wr.addr = to_addr(tgt);
        tab_wr.data = rec;
        if (rec.wfirst == '0) begin
          tab_wr.data.wfirst = self;
        end
        tab_wr.data.wlast = self;
        tab_raddr = to_addr(rec.wlast);
      end
      S_LK_LW: begin
        tab_wr.we = 1'b1;
        tab_wr.addr = to_addr(lid);
        tab_wr.data = rec;
        tab_wr.data.wnext = self;
      end
      S_PS_RD: begin
        tab_wr.we = 1'b1;
        tab_wr.addr = to_addr(self);
        tab_wr.data = rec;
        tab_wr.data.phase = PH_RUNNABLE;
        tab_wr.data.queued = rec.queued | wake_push;
        ring_req.push = wake_push;
        ring_req.push_id = self;
      end
      S_IDLE, S_FIN: begin
        tab_wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      created <= tid_t'(1);
      cur <= tid_t'(1);
      ja <= '0;
      alive <= tid_t'(1);
      halted <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (cmd_take) begin
            op <= op_in;
            tgt <= tgt_in;
            code <= code_in;
            self <= cur;
            st <= ST_DONE;
            rv <= '0;
            sw <= 1'b0;
            rvld <= 1'b0;
            rcode <= '0;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (halted) begin
            st <= ST_HALTED;
            state <= S_FIN;
          end else begin
            unique case (op)
              OP_CREATE: begin
                if (created >= tid_t'(MAX_THREADS)) begin
                  st <= ST_REJECTED;
                end else begin
                  created <= new_id;
                  alive <= alive + tid_t'(1);
                  rv <= 32'(new_id);
                end
                state <= S_FIN;
              end
              OP_EXIT: state <= S_EX_RD;
              OP_JOIN: begin
                if (tgt == self) begin
                  st <= ST_REJECTED;
                  state <= S_FIN;
                end else if (tgt == '0) begin
                  if (ja != '0) begin
                    st <= ST_REJECTED;
                    state <= S_FIN;
                  end else if (alive > tid_t'(1)) begin
                    ja <= self;
                    state <= S_JB_RD;
                  end else begin
                    state <= S_FIN;
                  end
                end else if (!id_ok(tgt, created)) begin
                  st <= ST_REJECTED;
                  state <= S_FIN;
                end else begin
                  state <= S_JT_RD;
                end
              end
              OP_PAUSE, OP_TICK: state <= (ring_fill != '0) ? S_PS_RD : S_FIN;
              default: begin
                st <= ST_REJECTED;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_EX_RD: begin
          w <= rec.wfirst;
          guard <= '0;
          if (alive != '0) begin
            alive <= alive - tid_t'(1);
          end
          state <= S_EX_WALK;
        end
        S_EX_WALK: begin
          if (w != '0 && id_ok(w, created) && guard < tid_t'(MAX_THREADS)) begin
            state <= S_EX_WK;
          end else begin
            state <= S_EX_JA;
          end
        end
        S_EX_WK: begin
          w <= rec.wnext;
          guard <= guard + tid_t'(1);
          state <= S_EX_WALK;
        end
        S_EX_JA: begin
          state <= (id_ok(ja, created) && alive <= tid_t'(1)) ? S_EX_JAW : S_POP0;
        end
        S_EX_JAW: state <= S_POP0;
        S_POP0: begin
          if (ring_fill == '0) begin
            priority case (op)
              OP_EXIT: begin
                halted <= 1'b1;
                st <= ST_HALTED;
                state <= S_FIN;
              end
              OP_JOIN: begin
                st <= ST_REJECTED;
                if (tgt == '0) begin
                  ja <= '0;
                end
                state <= S_RV_WR;
              end
              default: state <= S_RV_WR;
            endcase
          end else begin
            state <= S_POP1;
          end
        end
        S_POP1: begin
          if (id_ok(ring_pop_id, created)) begin
            nid <= ring_pop_id;
            state <= S_POP2;
          end else begin
            state <= S_POP0;
          end
        end
        S_POP2: begin
          if (rec.phase == PH_RUNNABLE) begin
            sw <= (nid != cur);
            cur <= nid;
            if (rec.rpend) begin
              rvld <= 1'b1;
              rcode <= rec.rval;
              if (ja == nid) begin
                ja <= '0;
              end
            end
            state <= (op == OP_JOIN && tgt != '0) ? S_LK_IS : S_FIN;
          end else begin
            state <= S_POP0;
          end
        end
        S_RV_WR: state <= S_FIN;
        S_JB_RD: state <= S_POP0;
        S_JT_RD: begin
          if (rec.phase == PH_EXITED) begin
            rv <= rec.exit_val;
            state <= S_FIN;
          end else begin
            state <= S_JC_RD;
          end
        end
        S_JC_RD: state <= S_POP0;
        S_LK_IS: state <= S_LK_RD;
        S_LK_RD: begin
          if (rec.wfirst != '0 && id_ok(rec.wlast, created)) begin
            lid <= rec.wlast;
            state <= S_LK_LW;
          end else begin
            state <= S_FIN;
          end
        end
        S_LK_LW: state <= S_FIN;
        S_PS_RD: state <= S_POP0;
        S_FIN: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/core/thread_scheduler_with_join.sv
`timescale 1ns / 1ps
// Round-robin thread scheduler with join.
// Command channel: cmd_valid/cmd_stall carry operation, target_thread and
// exit_value; a word is taken when cmd_valid is high and cmd_stall is low.
// Result channel: res_valid/res_stall carry status, return_value,
// running_thread, switched, resume_valid and resume_code, one word per command.
// One command is in flight at a time; the next may be taken while the last
// result still waits in the output register.
// The time from one accepted command to the next is set by the thread table
// read-modify-write sequencer (one write port, registered read data):
// create, rejected, halted, immediate join-all and pause/tick on an empty ring
// are shortest; join of an exited thread reads the target; pause/tick requeues
// the caller and pops ready entries; a join that blocks marks the caller
// blocked, pops entries and links it behind the target's last waiter; exit
// wakes each waiter, then the join-all waiter, then pops entries. The result
// becomes valid in the cycle that cmd_stall drops again.
// Reset: the init state writes the main thread entry, and once rst has
// fallen cmd_stall drops. Thread 1 runs, nothing else exists.
// A stalled result holds the output register; the core then waits with its
// finished result and takes no further command until the register frees.
module thread_scheduler_with_join (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  logic [2:0]           operation,
  input  logic [10:0]          target_thread,
  input  logic signed [31:0]   exit_value,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [1:0]           status,
  output logic signed [31:0]   return_value,
  output logic [10:0]          running_thread,
  output logic                 switched,
  output logic                 resume_valid,
  output logic signed [31:0]   resume_code
);
  import tsj_pkg::*;

  logic ready;
  logic fin;
  logic cmd_take;
  logic res_take;
  result_t res;
  tab_wr_t tab_wr;
  taddr_t tab_raddr;
  thread_rec_t tab_rdata;
  ring_req_t ring_req;
  tid_t ring_pop_id;
  tid_t ring_fill;

  assign cmd_stall = !ready;
  assign cmd_take = cmd_valid && ready;
  assign res_take = fin && (!res_valid || !res_stall);

  tsj_thread_tab u_tab (
    .clk   (clk),
    .wr    (tab_wr),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  tsj_ready_ring u_ring (
    .clk    (clk),
    .rst    (rst),
    .req    (ring_req),
    .pop_id (ring_pop_id),
    .fill   (ring_fill)
  );

  tsj_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_take    (cmd_take),
    .op_in       (operation),
    .tgt_in      (tid_t'(target_thread)),
    .code_in     (exit_value),
    .ready       (ready),
    .fin         (fin),
    .res_take    (res_take),
    .res         (res),
    .tab_wr      (tab_wr),
    .tab_raddr   (tab_raddr),
    .tab_rdata   (tab_rdata),
    .ring_req    (ring_req),
    .ring_pop_id (ring_pop_id),
    .ring_fill   (ring_fill)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (res_take) begin
      status <= res.status;
      return_value <= res.ret;
      running_thread <= 11'(res.running);
      switched <= res.switched;
      resume_valid <= res.rvld;
      resume_code <= res.rcode;
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> cmd_stall)
    else $error("core took a second word while busy");

  a_code_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (resume_valid || resume_code == '0))
    else $error("resume code without resume");

  a_switch_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && switched |-> status == ST_DONE)
    else $error("switch reported with non-done status");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_HALTED |-> !switched && !resume_valid)
    else $error("halted word reports a dispatch");

endmodule

// File: tb/thread_scheduler_with_join_tb.sv
`timescale 1ns / 1ps

module thread_scheduler_with_join_tb;
  import tsj_pkg::*;

  localparam int NTH = MAX_THREADS;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [2:0]  op;
    logic [10:0] tgt;
    logic [31:0] val;
  } cmd_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic [2:0] operation = '0;
  logic [10:0] target_thread = '0;
  logic signed [31:0] exit_value = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [1:0] status;
  logic signed [31:0] return_value;
  logic [10:0] running_thread;
  logic switched;
  logic resume_valid;
  logic signed [31:0] resume_code;

  thread_scheduler_with_join u_top (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .operation(operation), .target_thread(target_thread), .exit_value(exit_value),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .return_value(return_value), .running_thread(running_thread),
    .switched(switched), .resume_valid(resume_valid), .resume_code(resume_code)
  );

  cmd_word_t pending_cmds[$];
  result_t   expected_results[$];
  int errors = 0;
  int sent = 0;
  int cycles = 0;
  int idle_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // scheduler shadow state
  int     created, running, head, tail, fill, join_all, alive;
  bit     halted;
  phase_t phase [NTH];
  bit     inrdy [NTH];
  bit     rpend [NTH];
  logic [31:0] xcode [NTH];
  logic [31:0] rval [NTH];
  int     ring [NTH];
  int     wfirst [NTH];
  int     wlast [NTH];
  int     wnext [NTH];

  int     s_created, s_running, s_head, s_tail, s_fill, s_join_all, s_alive;
  bit     s_halted;
  phase_t s_phase [NTH];
  bit     s_inrdy [NTH];
  bit     s_rpend [NTH];
  logic [31:0] s_xcode [NTH];
  logic [31:0] s_rval [NTH];
  int     s_ring [NTH];
  int     s_wfirst [NTH];
  int     s_wlast [NTH];
  int     s_wnext [NTH];

  bit sw, rvld;
  logic [31:0] rcode;

  task automatic save_state();
    s_created = created; s_running = running; s_head = head; s_tail = tail;
    s_fill = fill; s_join_all = join_all; s_alive = alive; s_halted = halted;
    s_phase = phase; s_inrdy = inrdy; s_rpend = rpend; s_xcode = xcode; s_rval = rval;
    s_ring = ring; s_wfirst = wfirst; s_wlast = wlast; s_wnext = wnext;
  endtask

  task automatic restore_state();
    created = s_created; running = s_running; head = s_head; tail = s_tail;
    fill = s_fill; join_all = s_join_all; alive = s_alive; halted = s_halted;
    phase = s_phase; inrdy = s_inrdy; rpend = s_rpend; xcode = s_xcode; rval = s_rval;
    ring = s_ring; wfirst = s_wfirst; wlast = s_wlast; wnext = s_wnext;
  endtask

  function automatic bit id_ok(int id);
    return id >= 1 && id <= created && id <= NTH;
  endfunction

  task automatic ready_add(int id);
    if (!id_ok(id) || fill >= NTH) return;
    if (phase[id-1] != PH_RUNNABLE || inrdy[id-1]) return;
    ring[tail] = id;
    tail = (tail + 1) % NTH;
    fill++;
    inrdy[id-1] = 1'b1;
  endtask

  task automatic ready_take(output int id);
    int c;
    id = 0;
    while (fill > 0) begin
      c = ring[head];
      head = (head + 1) % NTH;
      fill--;
      if (id_ok(c)) begin
        inrdy[c-1] = 1'b0;
        if (phase[c-1] == PH_RUNNABLE) begin
          id = c;
          return;
        end
      end
    end
  endtask

  task automatic wake(int id, logic [31:0] code);
    phase[id-1] = PH_RUNNABLE;
    rpend[id-1] = 1'b1;
    rval[id-1] = code;
    ready_add(id);
  endtask

  task automatic unlink_waiter(int tg, int id);
    int prev, c, guard, nx;
    prev = 0; c = wfirst[tg-1]; guard = 0;
    while (c != 0 && id_ok(c) && guard < NTH) begin
      if (c == id) begin
        nx = wnext[c-1];
        if (prev == 0) wfirst[tg-1] = nx;
        else wnext[prev-1] = nx;
        if (wlast[tg-1] == id) wlast[tg-1] = prev;
        return;
      end
      prev = c;
      c = wnext[c-1];
      guard++;
    end
  endtask

  task automatic switch_to(int nxt);
    if (nxt != running) sw = 1'b1;
    running = nxt;
    phase[nxt-1] = PH_RUNNING;
    if (rpend[nxt-1]) begin
      rvld = 1'b1;
      rcode = rval[nxt-1];
      rpend[nxt-1] = 1'b0;
      if (join_all == nxt) join_all = 0;
    end
  endtask

  task automatic schedule_cmd(input cmd_word_t c, output result_t r);
    int cur, id, nxt, w, nx, guard, tg;
    logic [1:0] st;
    logic [31:0] rv;
    st = ST_DONE; rv = '0; sw = 1'b0; rvld = 1'b0; rcode = '0;
    cur = running;
    tg = int'(c.tgt);
    if (halted) begin
      st = ST_HALTED;
    end else if (c.op == OP_CREATE) begin
      if (created >= NTH) begin
        st = ST_REJECTED;
      end else begin
        created++;
        id = created;
        phase[id-1] = PH_RUNNABLE;
        inrdy[id-1] = 1'b0;
        xcode[id-1] = '0;
        wfirst[id-1] = 0;
        rpend[id-1] = 1'b0;
        alive++;
        ready_add(id);
        rv = 32'(id);
      end
    end else if (c.op == OP_EXIT) begin
      xcode[cur-1] = c.val;
      phase[cur-1] = PH_EXITED;
      if (alive > 0) alive--;
      w = wfirst[cur-1];
      guard = 0;
      while (w != 0 && id_ok(w) && guard < NTH) begin
        nx = wnext[w-1];
        if (phase[w-1] == PH_BLOCKED) wake(w, c.val);
        w = nx;
        guard++;
      end
      wfirst[cur-1] = 0;
      if (id_ok(join_all) && phase[join_all-1] == PH_BLOCKED && alive <= 1)
        wake(join_all, '0);
      ready_take(nxt);
      if (nxt == 0) begin
        halted = 1'b1;
        st = ST_HALTED;
      end else begin
        switch_to(nxt);
      end
    end else if (c.op == OP_JOIN) begin
      if (tg == cur) begin
        st = ST_REJECTED;
      end else if (tg == 0) begin
        if (join_all != 0) begin
          st = ST_REJECTED;
        end else if (alive > 1) begin
          phase[cur-1] = PH_BLOCKED;
          join_all = cur;
          ready_take(nxt);
          if (nxt == 0) begin
            phase[cur-1] = PH_RUNNING;
            join_all = 0;
            st = ST_REJECTED;
          end else begin
            switch_to(nxt);
          end
        end
      end else if (!id_ok(tg)) begin
        st = ST_REJECTED;
      end else if (phase[tg-1] == PH_EXITED) begin
        rv = xcode[tg-1];
      end else begin
        phase[cur-1] = PH_BLOCKED;
        wnext[cur-1] = 0;
        if (wfirst[tg-1] == 0) wfirst[tg-1] = cur;
        else if (id_ok(wlast[tg-1])) wnext[wlast[tg-1]-1] = cur;
        wlast[tg-1] = cur;
        ready_take(nxt);
        if (nxt == 0) begin
          phase[cur-1] = PH_RUNNING;
          unlink_waiter(tg, cur);
          st = ST_REJECTED;
        end else begin
          switch_to(nxt);
        end
      end
    end else if (c.op == OP_PAUSE || c.op == OP_TICK) begin
      if (fill > 0) begin
        phase[cur-1] = PH_RUNNABLE;
        ready_add(cur);
        ready_take(nxt);
        if (nxt == 0) phase[cur-1] = PH_RUNNING;
        else switch_to(nxt);
      end
    end else begin
      st = ST_REJECTED;
    end
    r.status = st;
    r.ret = rv;
    r.running = tid_t'(running);
    r.switched = sw;
    r.rvld = rvld;
    r.rcode = rcode;
  endtask

  // queue a command; a halting exit is turned into a pause unless allowed
  task automatic queue_cmd(input cmd_word_t c, input bit may_halt);
    result_t r;
    save_state();
    schedule_cmd(c, r);
    if (r.status == ST_HALTED && !s_halted && !may_halt) begin
      restore_state();
      c.op = OP_PAUSE;
      schedule_cmd(c, r);
    end
    pending_cmds.push_back(c);
    expected_results.push_back(r);
  endtask

  function automatic logic [31:0] pick_code();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_word_t pick_cmd();
    cmd_word_t c;
    int r;
    c.val = pick_code();
    c.tgt = 11'($urandom);
    r = $urandom_range(0, 99);
    if (r < 28) c.op = OP_CREATE;
    else if (r < 44) c.op = OP_EXIT;
    else if (r < 72) c.op = OP_JOIN;
    else if (r < 84) c.op = OP_PAUSE;
    else if (r < 96) c.op = OP_TICK;
    else c.op = 3'($urandom_range(5, 7));
    if (c.op == OP_JOIN) begin
      r = $urandom_range(0, 19);
      if (r < 2) c.tgt = '0;
      else if (r == 2) c.tgt = 11'(running);
      else if (r == 3) c.tgt = 11'($urandom);
      else if (r == 4 && created < 2047) c.tgt = 11'($urandom_range(created + 1, 2047));
      else c.tgt = 11'($urandom_range(1, created));
    end
    return c;
  endfunction

  function automatic cmd_word_t mk(logic [2:0] op, int tg, logic [31:0] v);
    cmd_word_t c;
    c.op = op; c.tgt = 11'(tg); c.val = v;
    return c;
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    int guard;
    created = 1; running = 1; head = 0; tail = 0; fill = 0;
    join_all = 0; alive = 1; halted = 1'b0;
    for (int i = 0; i < NTH; i++) begin
      phase[i] = PH_UNUSED; inrdy[i] = 0; rpend[i] = 0; xcode[i] = '0; rval[i] = '0;
      ring[i] = 0; wfirst[i] = 0; wlast[i] = 0; wnext[i] = 0;
    end
    phase[0] = PH_RUNNING;

    queue_cmd(mk(OP_JOIN, 0, 0), 0);
    queue_cmd(mk(OP_PAUSE, 0, 0), 0);
    queue_cmd(mk(OP_TICK, 0, 0), 0);
    queue_cmd(mk(OP_EXIT, 0, 32'h1234), 0);
    queue_cmd(mk(OP_CREATE, 0, 0), 0);
    queue_cmd(mk(OP_CREATE, 2047, 32'hffffffff), 0);
    queue_cmd(mk(OP_JOIN, 1, 0), 0);
    queue_cmd(mk(OP_JOIN, 2047, 0), 0);
    queue_cmd(mk(OP_JOIN, 4, 0), 0);
    queue_cmd(mk(OP_JOIN, 2, 0), 0);
    queue_cmd(mk(OP_JOIN, 0, 0), 0);
    queue_cmd(mk(OP_JOIN, 0, 0), 0);
    queue_cmd(mk(OP_EXIT, 0, 32'h7fffffff), 0);
    queue_cmd(mk(OP_JOIN, 3, 0), 0);
    queue_cmd(mk(OP_TICK, 0, 0), 0);
    queue_cmd(mk(OP_CREATE, 0, 0), 0);
    queue_cmd(mk(OP_EXIT, 0, 32'h80000000), 0);
    queue_cmd(mk(OP_JOIN, 3, 0), 0);
    queue_cmd(mk(OP_PAUSE, 0, 0), 0);
    queue_cmd(mk(3'd5, 0, 0), 0);
    queue_cmd(mk(3'd6, 1024, 0), 0);
    queue_cmd(mk(3'd7, 1, 0), 0);

    for (int i = 0; i < 700; i++) queue_cmd(pick_cmd(), 0);
    guard = 0;
    while (!halted && guard < 4000) begin
      if ($urandom_range(0, 9) == 0) queue_cmd(pick_cmd(), 0);
      else queue_cmd(mk(OP_EXIT, 0, pick_code()), 1);
      guard++;
    end
    for (int op = 0; op < 6; op++) queue_cmd(mk(3'(op), 2, 32'h55), 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_cmds.size() == 0 && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      idle_mode <= (sent / 200) % 4;
      if (pending_cmds.size() != 0 &&
          !((idle_mode == 1 || idle_mode == 3) &&
            $urandom_range(0, 99) < (idle_mode == 1 ? 63 : 11))) begin
        operation <= pending_cmds[0].op;
        target_thread <= pending_cmds[0].tgt;
        exit_value <= pending_cmds[0].val;
        void'(pending_cmds.pop_front());
        cmd_valid <= 1'b1;
        sent <= sent + 1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if (!hold_done && sent >= 120) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      res_stall <= 1'b1;
    end else begin
      res_stall <= (idle_mode == 2 || idle_mode == 3) &&
                   $urandom_range(0, 99) < (idle_mode == 2 ? 63 : 11);
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          errors++;
        end
        if (return_value !== e.ret) begin
          $error("return_value: expected %0d, got %0d", $signed(e.ret), return_value);
          errors++;
        end
        if (running_thread !== e.running) begin
          $error("running_thread: expected %0d, got %0d", e.running, running_thread);
          errors++;
        end
        if (switched !== e.switched) begin
          $error("switched: expected %0d, got %0d", e.switched, switched);
          errors++;
        end
        if (resume_valid !== e.rvld) begin
          $error("resume_valid: expected %0d, got %0d", e.rvld, resume_valid);
          errors++;
        end
        if (resume_code !== e.rcode) begin
          $error("resume_code: expected %0d, got %0d", $signed(e.rcode), resume_code);
          errors++;
        end
      end
    end
  end

endmodule

// File: files.f
rtl/core/tsj_pkg.sv
rtl/core/tsj_thread_tab.sv
rtl/core/tsj_ready_ring.sv
rtl/core/tsj_ctrl.sv
rtl/core/thread_scheduler_with_join.sv
tb/thread_scheduler_with_join_tb.sv
